>>> rtl/rpfu_pkg.sv
// shared types, codes and channel decode function for the raw pixel format unpacker
package rpfu_pkg;

    // pixel format codes
    localparam logic [3:0] FMT_GRAY1    = 4'd0;
    localparam logic [3:0] FMT_GRAY2    = 4'd1;
    localparam logic [3:0] FMT_GRAY4    = 4'd2;
    localparam logic [3:0] FMT_GRAY8    = 4'd3;
    localparam logic [3:0] FMT_RGBX5551 = 4'd4;
    localparam logic [3:0] FMT_XRGB1555 = 4'd5;
    localparam logic [3:0] FMT_RGB565   = 4'd6;
    localparam logic [3:0] FMT_RGB888   = 4'd7;
    localparam logic [3:0] FMT_RGB5A3   = 4'd8;
    localparam logic [3:0] FMT_XRGB666  = 4'd9;
    localparam logic [3:0] FMT_XRGB8888 = 4'd10;
    localparam logic [3:0] FMT_ARGB8888 = 4'd11;
    localparam logic [3:0] FMT_RGBX8888 = 4'd12;
    localparam logic [3:0] FMT_RGBA8888 = 4'd13;

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT  = 2'd0;
    localparam logic [1:0] CFG_LITTLE_ENDIAN = 2'd1;
    localparam logic [1:0] CFG_SKIP_BYTES    = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one unit of work handed from front to back
    typedef struct packed {
        logic [3:0]  fmt;
        logic [31:0] word;   // gray: byte in [7:0]; wide: assembled pixel
    } t_job;

    // returns {alpha, blue, green, red}
    function automatic logic [31:0] decode_wide(input logic [3:0] f, input logic [31:0] p);
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        logic [31:0] a;
        a = 32'h0000_00FF;
        case (f)
            FMT_RGBX5551: begin
                r = ((p >> 8) & 32'hF8) | ((p >> 13) & 32'h07);
                g = ((p >> 3) & 32'hF8) | ((p >> 8) & 32'h07);
                b = ((p << 2) & 32'hF8) | ((p >> 3) & 32'h07);
            end
            FMT_RGB565: begin
                r = ((p >> 8) & 32'hF8) | ((p >> 13) & 32'h07);
                g = ((p >> 3) & 32'hFC) | ((p >> 9) & 32'h03);
                b = ((p << 3) & 32'hF8) | ((p >> 2) & 32'h07);
            end
            FMT_XRGB1555, FMT_RGB5A3: begin
                if (f == FMT_RGB5A3 && p[15]) begin
                    r = ((p >> 4) & 32'hF0) | ((p >> 8) & 32'h0F);
                    g = (p & 32'hF0) | ((p >> 4) & 32'h0F);
                    b = ((p << 4) & 32'hF0) | (p & 32'h0F);
                    a = ((p >> 7) & 32'hE0) | ((p >> 10) & 32'h1C) | ((p >> 13) & 32'h03);
                end else begin
                    r = ((p >> 7) & 32'hF8) | ((p >> 12) & 32'h07);
                    g = ((p >> 2) & 32'hF8) | ((p >> 7) & 32'h07);
                    b = ((p << 3) & 32'hF8) | ((p >> 2) & 32'h07);
                end
            end
            FMT_XRGB666: begin
                r = ((p >> 10) & 32'hFC) | ((p >> 16) & 32'h03);
                g = ((p >> 4) & 32'hFC) | ((p >> 10) & 32'h03);
                b = ((p << 2) & 32'hFC) | ((p >> 4) & 32'h03);
            end
            FMT_RGB888, FMT_XRGB8888: begin
                r = p >> 16;
                g = p >> 8;
                b = p;
            end
            FMT_ARGB8888: begin
                r = p >> 16;
                g = p >> 8;
                b = p;
                a = p >> 24;
            end
            FMT_RGBX8888: begin
                r = p >> 24;
                g = p >> 16;
                b = p >> 8;
            end
            default: begin
                r = p >> 24;
                g = p >> 16;
                b = p >> 8;
                a = p;
            end
        endcase
        return {a[7:0], b[7:0], g[7:0], r[7:0]};
    endfunction

endpackage

>>> rtl/rpfu_front.sv
// front end: header skip, byte gathering, endian fix-up and job issue
module rpfu_front
    import rpfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_start,
    input  logic [3:0]  i_pixel_format,
    input  logic        i_little_endian,
    input  logic [15:0] i_skip_bytes,
    output logic        o_push,
    output t_job        o_job
);

    logic [15:0] r_skip_left;
    logic [15:0] n_skip_left;
    logic [23:0] r_gathered;
    logic [23:0] n_gathered;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    logic [15:0] skip_eff;
    logic [23:0] g_eff;
    logic [1:0]  cnt_eff;
    logic [2:0]  need;
    logic [31:0] be_word;
    logic [31:0] le_word;

    always_comb begin
        case (i_pixel_format)
            FMT_GRAY1, FMT_GRAY2, FMT_GRAY4, FMT_GRAY8: need = 3'd1;
            FMT_RGB888:                                  need = 3'd3;
            FMT_RGBX5551, FMT_XRGB1555, FMT_RGB565, FMT_RGB5A3: need = 3'd2;
            default:                                     need = 3'd4;
        endcase
    end

    always_comb begin
        skip_eff = i_stream_start ? i_skip_bytes : r_skip_left;
        g_eff    = i_stream_start ? 24'd0 : r_gathered;
        cnt_eff  = i_stream_start ? 2'd0 : r_count;

        case (need)
            3'd2: begin
                be_word = {16'd0, g_eff[7:0], i_data_byte};
                le_word = {16'd0, i_data_byte, g_eff[7:0]};
            end
            3'd3: begin
                be_word = {8'd0, g_eff[15:0], i_data_byte};
                le_word = {8'd0, i_data_byte, g_eff[7:0], g_eff[15:8]};
            end
            default: begin
                be_word = {g_eff, i_data_byte};
                le_word = {i_data_byte, g_eff[7:0], g_eff[15:8], g_eff[23:16]};
            end
        endcase

        n_skip_left = skip_eff;
        n_gathered  = g_eff;
        n_count     = cnt_eff;
        o_push      = 1'b0;
        o_job.fmt   = i_pixel_format;
        o_job.word  = {24'd0, i_data_byte};

        if (skip_eff != 16'd0) begin
            n_skip_left = skip_eff - 16'd1;
        end else if (i_pixel_format > FMT_RGBA8888) begin
            n_gathered = 24'd0;
            n_count    = 2'd0;
        end else if (need == 3'd1) begin
            n_gathered = 24'd0;
            n_count    = 2'd0;
            o_push     = i_accept;
        end else if ({1'b0, cnt_eff} + 3'd1 < need) begin
            n_gathered = {g_eff[15:0], i_data_byte};
            n_count    = cnt_eff + 2'd1;
        end else begin
            n_gathered = 24'd0;
            n_count    = 2'd0;
            o_push     = i_accept;
            o_job.word = i_little_endian ? le_word : be_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_left <= 16'd0;
            r_gathered  <= 24'd0;
            r_count     <= 2'd0;
        end else if (i_accept) begin
            r_skip_left <= n_skip_left;
            r_gathered  <= n_gathered;
            r_count     <= n_count;
        end
    end

endmodule

>>> rtl/rpfu_queue.sv
// short job queue between front and back
module rpfu_queue
    import rpfu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/rpfu_back.sv
// back end: gray pixel expansion, wide pixel decode and output register
module rpfu_back
    import rpfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,
    output logic        o_tlast
);

    logic [2:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_last;

    logic        load;
    logic [2:0]  last_idx;
    logic [2:0]  shamt;
    logic [7:0]  sh;
    logic [7:0]  v;
    logic [31:0] pix;

    always_comb begin
        case (i_job.fmt)
            FMT_GRAY1: begin
                last_idx = 3'd7;
                shamt    = r_idx;
            end
            FMT_GRAY2: begin
                last_idx = 3'd3;
                shamt    = {r_idx[1:0], 1'b0};
            end
            FMT_GRAY4: begin
                last_idx = 3'd1;
                shamt    = {r_idx[0], 2'b00};
            end
            default: begin
                last_idx = 3'd0;
                shamt    = 3'd0;
            end
        endcase
        sh = i_job.word[7:0] << shamt;

        // gray1 is inverted: a set bit is black
        case (i_job.fmt)
            FMT_GRAY1: v = sh[7] ? 8'h00 : 8'hFF;
            FMT_GRAY2: v = {4{sh[7:6]}};
            FMT_GRAY4: v = {2{sh[7:4]}};
            default:   v = i_job.word[7:0];
        endcase

        if (i_job.fmt <= FMT_GRAY8) begin
            pix = {8'hFF, v, v, v};
        end else begin
            pix = decode_wide(i_job.fmt, i_job.word);
        end
    end

    assign load     = i_valid && (!r_out_valid || i_tready);
    assign o_pop    = load && (r_idx == last_idx);
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data <= pix;
            r_out_last <= (r_idx == last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= (r_idx == last_idx) ? 3'd0 : r_idx + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/raw_pixel_format_unpacker.sv
// top level of the raw pixel format unpacker: config registers, front, queue and back
// Takes one raw byte per transaction and delivers RGBA8888 pixels. Gray8 and the wide
// formats sustain one byte per cycle while the receiver does not stall (a wide pixel
// comes out on the transaction that completes it); gray4, gray2 and gray1 bytes each
// yield 2, 4 and 8 pixels, stepped out by the back-end pixel counter, and the two-entry
// job queue back-pressures the input while they drain. Skipped header bytes and bytes
// that only gather part of a pixel are taken with no pixel out. A completing byte
// reaches its first pixel through the queue entry and then the output register.
// Configuration may only be changed while no pixels are outstanding.
module raw_pixel_format_unpacker
    import rpfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] stream_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic        m_axis_tlast     // last_of_run
);

    logic [3:0]  r_pixel_format;
    logic        r_little_endian;
    logic [15:0] r_skip_bytes;

    logic accept;
    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_job front_job;
    t_job head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format  <= FMT_GRAY1;
            r_little_endian <= 1'b0;
            r_skip_bytes    <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIXEL_FORMAT:  r_pixel_format  <= i_cfg_data[3:0];
                CFG_LITTLE_ENDIAN: r_little_endian <= i_cfg_data[0];
                CFG_SKIP_BYTES:    r_skip_bytes    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    rpfu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (s_axis_tdata),
        .i_stream_start  (s_axis_tuser),
        .i_pixel_format  (r_pixel_format),
        .i_little_endian (r_little_endian),
        .i_skip_bytes    (r_skip_bytes),
        .o_push          (push),
        .o_job           (front_job)
    );

    rpfu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    rpfu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

>>> verif/raw_pixel_format_unpacker_checker.sv
// pixel predictor and scoreboard watching the byte and pixel channels of the unpacker
module raw_pixel_format_unpacker_checker
    import rpfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] stream_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    input  logic        m_axis_tlast,    // last_of_run
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       is_last;
    } t_pixel;

    t_pixel      expected_pixels[$];
    t_pixel      want;

    logic [3:0]  fmt_q;
    logic        le_q;
    logic [15:0] skip_cfg;
    logic [15:0] skip_left;
    logic [23:0] held_bytes;
    logic [1:0]  held_n;

    function automatic int pixel_bytes(input logic [3:0] f);
        if (f <= FMT_GRAY8) return 1;
        if (f == FMT_RGB888) return 3;
        if (f <= FMT_RGB5A3) return 2;
        return 4;
    endfunction

    // channel widening repeats the top bits of each field into the low bits
    function automatic t_pixel wide_pixel(input logic [3:0] f, input logic [31:0] p);
        t_pixel px;
        px = '0;
        px.alpha = 8'hFF;
        case (f)
            FMT_RGBX5551: begin
                px.red   = {p[15:11], p[15:13]};
                px.green = {p[10:6], p[10:8]};
                px.blue  = {p[5:1], p[5:3]};
            end
            FMT_RGB565: begin
                px.red   = {p[15:11], p[15:13]};
                px.green = {p[10:5], p[10:9]};
                px.blue  = {p[4:0], p[4:2]};
            end
            FMT_XRGB1555, FMT_RGB5A3: begin
                if (f == FMT_RGB5A3 && p[15]) begin
                    px.red   = {2{p[11:8]}};
                    px.green = {2{p[7:4]}};
                    px.blue  = {2{p[3:0]}};
                    px.alpha = {p[14:12], p[14:12], p[14:13]};
                end else begin
                    px.red   = {p[14:10], p[14:12]};
                    px.green = {p[9:5], p[9:7]};
                    px.blue  = {p[4:0], p[4:2]};
                end
            end
            FMT_XRGB666: begin
                px.red   = {p[17:12], p[17:16]};
                px.green = {p[11:6], p[11:10]};
                px.blue  = {p[5:0], p[5:4]};
            end
            FMT_RGB888, FMT_XRGB8888: begin
                px.red   = p[23:16];
                px.green = p[15:8];
                px.blue  = p[7:0];
            end
            FMT_ARGB8888: begin
                px.red   = p[23:16];
                px.green = p[15:8];
                px.blue  = p[7:0];
                px.alpha = p[31:24];
            end
            FMT_RGBX8888: begin
                px.red   = p[31:24];
                px.green = p[23:16];
                px.blue  = p[15:8];
            end
            default: begin
                px.red   = p[31:24];
                px.green = p[23:16];
                px.blue  = p[15:8];
                px.alpha = p[7:0];
            end
        endcase
        return px;
    endfunction

    task automatic push_gray(input logic [7:0] v, input logic is_last);
        t_pixel px;
        px.red     = v;
        px.green   = v;
        px.blue    = v;
        px.alpha   = 8'hFF;
        px.is_last = is_last;
        expected_pixels.push_back(px);
    endtask

    task automatic unpack_byte(input logic [7:0] b, input logic start);
        logic [31:0] word;
        logic [31:0] swapped;
        t_pixel      px;
        int          need;
        int          i;
        if (start) begin
            held_bytes = '0;
            held_n     = '0;
            skip_left  = skip_cfg;
        end
        if (skip_left != 16'd0) begin
            skip_left = skip_left - 16'd1;
            return;
        end
        if (fmt_q > FMT_RGBA8888) begin
            held_bytes = '0;
            held_n     = '0;
            return;
        end
        if (fmt_q <= FMT_GRAY8) begin
            held_bytes = '0;
            held_n     = '0;
            case (fmt_q)
                // gray1 is inverted: a set bit is black
                FMT_GRAY1: for (i = 7; i >= 0; i--) push_gray(b[i] ? 8'h00 : 8'hFF, i == 0);
                FMT_GRAY2: for (i = 3; i >= 0; i--) push_gray({4{b[2*i +: 2]}}, i == 0);
                FMT_GRAY4: for (i = 1; i >= 0; i--) push_gray({2{b[4*i +: 4]}}, i == 0);
                default:   push_gray(b, 1'b1);
            endcase
            return;
        end
        need = pixel_bytes(fmt_q);
        if (held_n + 1 < need) begin
            held_bytes = {held_bytes[15:0], b};
            held_n     = held_n + 2'd1;
            return;
        end
        // the newest bytes of the pixel size win, older held bytes drop out
        word = {held_bytes, b};
        if (need == 2) word = word & 32'h0000_FFFF;
        else if (need == 3) word = word & 32'h00FF_FFFF;
        if (le_q) begin
            swapped = '0;
            for (i = 0; i < need; i++) begin
                swapped = {swapped[23:0], word[7:0]};
                word    = word >> 8;
            end
            word = swapped;
        end
        held_bytes = '0;
        held_n     = '0;
        px = wide_pixel(fmt_q, word);
        px.is_last = 1'b1;
        expected_pixels.push_back(px);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_q        = FMT_GRAY1;
            le_q         = 1'b0;
            skip_cfg     = '0;
            skip_left    = '0;
            held_bytes   = '0;
            held_n       = '0;
            o_fail_count = 0;
            expected_pixels.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel %h with no transaction expected", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_pixels[0];
                    expected_pixels.delete(0);
                    if (m_axis_tdata[7:0] !== want.red) begin
                        $error("red expected %h actual %h", want.red, m_axis_tdata[7:0]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[15:8] !== want.green) begin
                        $error("green expected %h actual %h", want.green, m_axis_tdata[15:8]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[23:16] !== want.blue) begin
                        $error("blue expected %h actual %h", want.blue, m_axis_tdata[23:16]);
                        o_fail_count++;
                    end
                    if (m_axis_tdata[31:24] !== want.alpha) begin
                        $error("alpha expected %h actual %h", want.alpha, m_axis_tdata[31:24]);
                        o_fail_count++;
                    end
                    if (m_axis_tlast !== want.is_last) begin
                        $error("last_of_run expected %b actual %b", want.is_last, m_axis_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                unpack_byte(s_axis_tdata, s_axis_tuser);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PIXEL_FORMAT:  fmt_q    = i_cfg_data[3:0];
                    CFG_LITTLE_ENDIAN: le_q     = i_cfg_data[0];
                    CFG_SKIP_BYTES:    skip_cfg = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

>>> verif/raw_pixel_format_unpacker_tb.sv
// stimulus, clocking and verdict for the raw pixel format unpacker
module raw_pixel_format_unpacker_tb;
    import rpfu_pkg::*;

    // format codes the block leaves undefined
    localparam logic [3:0] FMT_UNDEF_LO = 4'd14;
    localparam logic [3:0] FMT_UNDEF_HI = 4'd15;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] data_byte
    logic        s_axis_tuser;    // [0] stream_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    logic        m_axis_tlast;    // last_of_run

    int fail_count;
    int pending;
    int cycle_count;
    int stall_left;
    bit idle_on;

    raw_pixel_format_unpacker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    raw_pixel_format_unpacker_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("raw_pixel_format_unpacker_tb failed");
                $finish;
            end
        end
    end

    // receiver back-pressure in short bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // bytes that only gather or get skipped may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input logic [3:0] fmt, input logic le, input logic [15:0] skip);
        logic [15:0] junk;
        junk = 16'($urandom);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PIXEL_FORMAT;
        i_cfg_data  <= {junk[15:4], fmt};
        @(negedge i_clk);
        i_cfg_index <= CFG_LITTLE_ENDIAN;
        i_cfg_data  <= {junk[15:1], le};
        @(negedge i_clk);
        i_cfg_index <= CFG_SKIP_BYTES;
        i_cfg_data  <= skip;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int          ph;
        int          k;
        logic [3:0]  fmt;
        logic [15:0] skip;
        logic        start;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_PIXEL_FORMAT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        idle_on       = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // gray formats at reset settings and after writes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        configure(FMT_GRAY2, 1'b0, 16'd0);
        send_byte(8'hE4, 1'b1);
        configure(FMT_GRAY4, 1'b0, 16'd0);
        send_byte(8'h0F, 1'b0);
        configure(FMT_GRAY8, 1'b0, 16'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // both branches of rgb5a3
        configure(FMT_RGB5A3, 1'b0, 16'd0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        // header skip, start byte itself dropped
        configure(FMT_GRAY8, 1'b0, 16'd2);
        send_byte(8'h11, 1'b1);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        // format changed with three bytes held
        configure(FMT_ARGB8888, 1'b0, 16'd0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        configure(FMT_RGB565, 1'b1, 16'd0);
        send_byte(8'h04, 1'b0);
        // undefined formats clear a partial pixel
        configure(FMT_RGB888, 1'b0, 16'd0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hBB, 1'b0);
        configure(FMT_UNDEF_LO, 1'b0, 16'd0);
        send_byte(8'hCC, 1'b0);
        configure(FMT_UNDEF_HI, 1'b1, 16'd0);
        send_byte(8'hDD, 1'b0);
        configure(FMT_RGB888, 1'b1, 16'd0);
        send_byte(8'h10, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);

        // longer header
        configure(FMT_GRAY8, 1'b0, 16'd20);
        for (k = 0; k < 20 + 4; k++)
            send_byte(8'($urandom), k == 0);

        // random streams, every format in turn
        for (ph = 0; ph < 14; ph++) begin
            fmt  = 4'((ph * 5) % 14);
            skip = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 6)) : 16'd0;
            if (ph >= 12) idle_on = 1'b0;
            configure(fmt, 1'($urandom), skip);
            for (k = 0; k < 18; k++) begin
                // most phases open a new stream, a few carry held bytes over
                start = (k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 19) == 0;
                send_byte(8'($urandom), start);
            end
            if (ph == 6) begin
                configure($urandom_range(0, 1) ? FMT_UNDEF_LO : FMT_UNDEF_HI, 1'($urandom),
                          16'd0);
                for (k = 0; k < 4; k++)
                    send_byte(8'($urandom), 1'($urandom));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4 * DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("raw_pixel_format_unpacker_tb passed");
        end else begin
            $display("raw_pixel_format_unpacker_tb failed");
        end
        $finish;
    end

endmodule
